FILE: rtl/core/flow_blur_kernel_triplets_top_macros.svh
// Assertion macros shared by the flow blur kernel RTL
`ifndef FLOW_BLUR_KERNEL_TRIPLETS_TOP_MACROS_SVH
`define FLOW_BLUR_KERNEL_TRIPLETS_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define FBK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbk assertion failed");

// next-cycle implication, disabled during reset
`define FBK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbk assertion failed");

`endif

FILE: rtl/core/fbk_pkg.sv
// Shared types and constants of the flow blur kernel triplet generator
package fbk_pkg;

    localparam int DIV_NUM_W = 38;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_Q_W   = 16;
    localparam int SQ_RAD_W  = 32;
    localparam int SQ_ROOT_W = 16;
    localparam int DIM_W     = 13;
    localparam int IDX_W     = 21;
    localparam int WGT_W     = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_TIME_SCALE   = 2'd0;
    localparam logic [1:0] CFG_FRAME_COUNT  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd3;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_Q_W-1:0]   quot;
        logic [DIV_DEN_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic                start;
        logic [SQ_RAD_W-1:0] rad;
    } t_sqrt_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [SQ_ROOT_W-1:0] root;
    } t_sqrt_rsp;

endpackage

FILE: rtl/core/fbk_div.sv
// Iterative restoring divider, one quotient bit per cycle
module fbk_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbk_pkg::t_div_req i_req,
    output fbk_pkg::t_div_rsp o_rsp
);

    localparam int QW = fbk_pkg::DIV_Q_W;
    localparam int DW = fbk_pkg::DIV_DEN_W;
    localparam int NW = fbk_pkg::DIV_NUM_W;

    logic          r_busy;
    logic          r_done;
    logic [3:0]    r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_lo;
    logic [QW-1:0] r_quot;
    logic [DW:0]   trial;
    logic          fits;

    // trial subtraction of one step
    assign trial = {r_rem, r_lo[QW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= DW'(i_req.num[NW-1:QW]);
                r_lo   <= i_req.num[QW-1:0];
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem  <= fits ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
                r_quot <= {r_quot[QW-2:0], fits};
                r_lo   <= {r_lo[QW-2:0], 1'b0};
                r_cnt  <= r_cnt + 4'd1;
                if (r_cnt == 4'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

FILE: rtl/core/fbk_sqrt.sv
// Iterative integer square root, one root bit per cycle
module fbk_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fbk_pkg::t_sqrt_req i_req,
    output fbk_pkg::t_sqrt_rsp o_rsp
);

    localparam int RW = fbk_pkg::SQ_ROOT_W;

    logic                         r_busy;
    logic                         r_done;
    logic [3:0]                   r_cnt;
    logic [fbk_pkg::SQ_RAD_W-1:0] r_rad;
    logic [RW:0]                  r_rem;
    logic [RW-1:0]                r_root;
    logic [RW+2:0]                rem_s;
    logic [RW+2:0]                trial;
    logic                         fits;

    // bring down two radicand bits, try root*4+1
    assign rem_s = {r_rem, r_rad[fbk_pkg::SQ_RAD_W-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign fits  = rem_s >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_req.rad;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rem  <= fits ? (RW+1)'(rem_s - trial) : rem_s[RW:0];
                r_root <= {r_root[RW-2:0], fits};
                r_rad  <= {r_rad[fbk_pkg::SQ_RAD_W-3:0], 2'b00};
                r_cnt  <= r_cnt + 4'd1;
                if (r_cnt == 4'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

FILE: rtl/core/flow_blur_kernel_triplets_top.sv
// Top level of the flow blur kernel triplet generator: sequencer, shared multiplier
//
//  channel   | dir | handshake                      | payload
//  s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready| four Q8.8 flows in tdata
//  m_axis    | out | o_m_axis_tvalid/i_m_axis_tready| triplet in tdata, tlast
//  cfg       | in  | i_cfg_valid/o_cfg_ready        | i_cfg_addr, i_cfg_data
//
// For each pixel the sequencer runs two square roots and six divisions, then per frame
// one accumulate step (S_ACC) and two off-diagonal beats, each through the steps
// S_CALC, S_IDX and S_OUT.
// The input is not ready from acceptance until the last beat is in the output register.
// A stalled output holds the sequencer at the emitting step; nothing is dropped.
// Reset is synchronous, active low; it restores register defaults and clears the counters.
module flow_blur_kernel_triplets_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_FRAMES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // fwd_flow_x, fwd_flow_y, bwd_flow_x, bwd_flow_y (16 bits each)
    input  logic [63:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // row_index (21), col_index (21), weight (16), zero pad (6)
    output logic [63:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

`include "flow_blur_kernel_triplets_top_macros.svh"

    localparam int DW = fbk_pkg::DIM_W;
    localparam int IW = fbk_pkg::IDX_W;
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_SQS, S_SQRT, S_DEN, S_DIAG, S_DIAGW, S_FT, S_FTW,
        S_PM, S_PD, S_PW, S_RI, S_DOUT, S_ACC, S_CALC, S_IDX, S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [15:0]   r_tau;
    logic [4:0]    r_cfg_f;
    logic [10:0]   r_cfg_w;
    logic [10:0]   r_cfg_h;

    // per-pixel working registers
    logic [4:0]    r_nf;
    logic [DW-1:0] r_w;
    logic [DW-1:0] r_h;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [15:0]   r_mag [4];
    logic [3:0]    r_neg;
    logic [1:0]    r_k;
    logic [31:0]   r_sum;
    logic [15:0]   r_a;
    logic [15:0]   r_b;
    logic [31:0]   r_den;
    logic [31:0]   r_p;
    logic [15:0]   r_diag;
    logic [15:0]   r_ft;
    logic [15:0]   r_offw;
    logic [11:0]   r_qp [4];
    logic [24:0]   r_rp [4];
    logic [12:0]   r_qa [4];
    logic [24:0]   r_ra [4];
    logic [IW-1:0] r_ri;
    logic [IW-1:0] r_ci;
    logic [DW-1:0] r_x;
    logic [DW-1:0] r_y;
    logic [4:0]    r_f;
    logic          r_dir;

    // output register
    logic          r_out_valid;
    logic [IW-1:0] r_out_row;
    logic [IW-1:0] r_out_col;
    logic [15:0]   r_out_wgt;
    logic          r_out_last;

    fbk_pkg::t_div_req  div_req;
    fbk_pkg::t_div_rsp  div_rsp;
    fbk_pkg::t_sqrt_req sq_req;
    fbk_pkg::t_sqrt_rsp sq_rsp;

    logic          in_fire;
    logic          slot_free;
    logic          out_load;
    logic [15:0]   mul_a;
    logic [15:0]   mul_b;
    logic [31:0]   prod;
    logic [4:0]    eff_f;
    logic [DW-1:0] eff_w;
    logic [DW-1:0] eff_h;
    logic [15:0]   flow [4];
    logic [5:0]    odd;
    logic [24:0]   den_d;
    logic [16:0]   offw_sum;
    logic          last_beat;
    logic [DW-1:0] col_x;
    logic [DW-1:0] row_x;
    logic [15:0]   x_raw;
    logic [15:0]   y_raw;
    logic [DW-1:0] x_cl;
    logic [DW-1:0] y_cl;
    logic [IW-1:0] ci;
    logic [DW:0]   col_nx;
    logic [DW:0]   row_nx;

    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign slot_free       = !r_out_valid || i_m_axis_tready;
    assign out_load        = slot_free && (r_state == S_DOUT || r_state == S_OUT);

    // effective frame count and image size
    always_comb begin
        eff_f = r_cfg_f;
        if (r_cfg_f == 5'd0) eff_f = 5'd1;
        else if (r_cfg_f > 5'(MAX_FRAMES)) eff_f = 5'(MAX_FRAMES);
        eff_w = DW'(r_cfg_w);
        if (r_cfg_w == 11'd0) eff_w = DW'(1);
        else if (DW'(r_cfg_w) > DW'(MAX_WIDTH)) eff_w = DW'(MAX_WIDTH);
        eff_h = DW'(r_cfg_h);
        if (r_cfg_h == 11'd0) eff_h = DW'(1);
        else if (DW'(r_cfg_h) > DW'(MAX_HEIGHT)) eff_h = DW'(MAX_HEIGHT);
    end

    // input flow fields
    for (genvar g = 0; g < 4; g++) begin : g_flow
        assign flow[g] = i_s_axis_tdata[16*g +: 16];
    end

    assign col_x    = DW'(r_col);
    assign row_x    = DW'(r_row);
    assign odd      = {r_nf, 1'b1};
    assign den_d    = {r_nf, 20'd0};
    assign offw_sum = {1'b0, r_diag} + {1'b0, r_ft};
    assign last_beat = (r_f == r_nf) && r_dir;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQX: begin
                mul_a = r_mag[{r_k[0], 1'b0}];
                mul_b = r_mag[{r_k[0], 1'b0}];
            end
            S_SQY: begin
                mul_a = r_mag[{r_k[0], 1'b1}];
                mul_b = r_mag[{r_k[0], 1'b1}];
            end
            S_DEN: begin
                mul_a = r_a;
                mul_b = r_b;
            end
            S_PM: begin
                mul_a = r_mag[r_k];
                mul_b = r_tau;
            end
            S_RI: begin
                mul_a = 16'(row_x);
                mul_b = 16'(r_w);
            end
            S_IDX: begin
                mul_a = 16'(r_y);
                mul_b = 16'(r_w);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // shared unit requests
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        unique case (r_state)
            S_DIAG: begin
                div_req.start = 1'b1;
                div_req.num   = {({1'b0, r_a} + {1'b0, r_b}), 21'd0}
                              + 38'(r_den[31:1]);
                div_req.den   = r_den;
            end
            S_FT: begin
                div_req.start = 1'b1;
                div_req.num   = 38'(32768) + 38'(odd);
                div_req.den   = 32'({odd, 1'b0});
            end
            S_PD: begin
                div_req.start = 1'b1;
                div_req.num   = 38'(r_p);
                div_req.den   = 32'(den_d);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end
    assign sq_req.start = (r_state == S_SQS);
    assign sq_req.rad   = r_sum;

    // displaced, clamped position for the current direction
    always_comb begin
        logic [12:0] qx;
        logic [12:0] qy;
        logic        nx;
        logic        ny;
        qx = r_dir ? r_qa[2] : r_qa[0];
        qy = r_dir ? r_qa[3] : r_qa[1];
        nx = r_dir ? r_neg[2] : r_neg[0];
        ny = r_dir ? r_neg[3] : r_neg[1];
        x_raw = nx ? 16'(col_x) + 16'(qx) : 16'(col_x) - 16'(qx);
        y_raw = ny ? 16'(row_x) + 16'(qy) : 16'(row_x) - 16'(qy);
        if (x_raw[15]) x_cl = '0;
        else if (x_raw > 16'(r_w - DW'(1))) x_cl = r_w - DW'(1);
        else x_cl = DW'(x_raw);
        if (y_raw[15]) y_cl = '0;
        else if (y_raw > 16'(r_h - DW'(1))) y_cl = r_h - DW'(1);
        else y_cl = DW'(y_raw);
    end

    assign ci     = prod[IW-1:0] + IW'(r_x) + IW'(1);
    assign col_nx = {1'b0, col_x} + (DW+1)'(1);
    assign row_nx = {1'b0, row_x} + (DW+1)'(1);

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau   <= 16'd4096;
            r_cfg_f <= 5'd1;
            r_cfg_w <= 11'd1024;
            r_cfg_h <= 11'd1024;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                fbk_pkg::CFG_TIME_SCALE:   r_tau   <= i_cfg_data;
                fbk_pkg::CFG_FRAME_COUNT:  r_cfg_f <= i_cfg_data[4:0];
                fbk_pkg::CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data[10:0];
                fbk_pkg::CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data[10:0];
            endcase
        end
    end

    // sequencer, working registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_k         <= '0;
            r_f         <= '0;
            r_dir       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) r_out_valid <= 1'b1;
            else if (i_m_axis_tready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        for (int i = 0; i < 4; i++) begin
                            r_neg[i] <= flow[i][15];
                            r_mag[i] <= flow[i][15] ? 16'(~flow[i] + 16'd1) : flow[i];
                        end
                        r_nf <= eff_f;
                        r_w  <= eff_w;
                        r_h  <= eff_h;
                        if (col_x >= eff_w) r_col <= '0;
                        if (row_x >= eff_h) r_row <= '0;
                        r_k     <= '0;
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_sum   <= prod;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sum   <= r_sum + prod;
                    r_state <= S_SQS;
                end
                S_SQS: r_state <= S_SQRT;
                S_SQRT: begin
                    if (sq_rsp.done) begin
                        if (r_k[0]) begin
                            r_b     <= sq_rsp.root + 16'd256;
                            r_k     <= '0;
                            r_state <= S_DEN;
                        end else begin
                            r_a     <= sq_rsp.root + 16'd256;
                            r_k     <= 2'd1;
                            r_state <= S_SQX;
                        end
                    end
                end
                S_DEN: begin
                    r_den   <= prod;
                    r_state <= S_DIAG;
                end
                S_DIAG: r_state <= S_DIAGW;
                S_DIAGW: begin
                    if (div_rsp.done) begin
                        r_diag  <= div_rsp.quot;
                        r_state <= S_FT;
                    end
                end
                S_FT: r_state <= S_FTW;
                S_FTW: begin
                    if (div_rsp.done) begin
                        r_ft    <= div_rsp.quot;
                        r_k     <= '0;
                        r_state <= S_PM;
                    end
                end
                S_PM: begin
                    r_p     <= prod;
                    r_state <= S_PD;
                end
                S_PD: r_state <= S_PW;
                S_PW: begin
                    if (div_rsp.done) begin
                        r_qp[r_k] <= div_rsp.quot[11:0];
                        r_rp[r_k] <= div_rsp.rem[24:0];
                        r_k       <= r_k + 2'd1;
                        r_state   <= (r_k == 2'd3) ? S_RI : S_PM;
                    end
                end
                S_RI: begin
                    r_ri <= prod[IW-1:0] + IW'(col_x) + IW'(1);
                    for (int i = 0; i < 4; i++) begin
                        r_qa[i] <= '0;
                        r_ra[i] <= {1'b0, r_nf, 19'd0};
                    end
                    r_offw  <= offw_sum[16] ? 16'hFFFF : offw_sum[15:0];
                    r_f     <= 5'd1;
                    r_dir   <= 1'b0;
                    r_state <= S_DOUT;
                end
                S_DOUT: begin
                    if (slot_free) begin
                        r_out_row   <= r_ri;
                        r_out_col   <= r_ri;
                        r_out_wgt   <= r_diag;
                        r_out_last  <= 1'b0;
                        r_state     <= S_ACC;
                    end
                end
                S_ACC: begin
                    // step every displacement by one frame
                    for (int i = 0; i < 4; i++) begin
                        logic [25:0] s;
                        s = {1'b0, r_ra[i]} + {1'b0, r_rp[i]};
                        if (s >= {1'b0, den_d}) begin
                            r_ra[i] <= 25'(s - {1'b0, den_d});
                            r_qa[i] <= r_qa[i] + 13'(r_qp[i]) + 13'd1;
                        end else begin
                            r_ra[i] <= s[24:0];
                            r_qa[i] <= r_qa[i] + 13'(r_qp[i]);
                        end
                    end
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_x     <= x_cl;
                    r_y     <= y_cl;
                    r_state <= S_IDX;
                end
                S_IDX: begin
                    r_ci    <= ci;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (slot_free) begin
                        r_out_row   <= r_ri;
                        r_out_col   <= r_ci;
                        r_out_wgt   <= (r_x == '0 && r_y == '0) ? 16'd0 : r_offw;
                        r_out_last  <= last_beat;
                        if (last_beat) begin
                            // advance raster position
                            if (col_nx >= {1'b0, r_w}) begin
                                r_col <= '0;
                                if (row_nx >= {1'b0, r_h}) r_row <= '0;
                                else r_row <= RW'(row_nx);
                            end else begin
                                r_col <= CW'(col_nx);
                            end
                            r_state <= S_IDLE;
                        end else if (!r_dir) begin
                            r_dir   <= 1'b1;
                            r_state <= S_CALC;
                        end else begin
                            r_dir   <= 1'b0;
                            r_f     <= r_f + 5'd1;
                            r_state <= S_ACC;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    fbk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    fbk_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_wgt, r_out_col, r_out_row};
    assign o_m_axis_tlast  = r_out_last;

    `FBK_ASSERT_IMPL(a_div_start_idle, i_clk, i_rst_n, div_req.start, !div_rsp.busy)
    `FBK_ASSERT_NEXT(a_accept_blocks, i_clk, i_rst_n, in_fire, !o_s_axis_tready)
    `FBK_ASSERT_IMPL(a_col_in_range, i_clk, i_rst_n, r_state == S_OUT, col_x < r_w)

endmodule
